/* rtl/assert_macros.svh */
// assertion macros shared by the rtl of the sparse polynomial merge adder
// depends on nothing; empty bodies under SYNTHESIS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPMA_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define SPMA_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SPMA_ASSERT(lbl, clk, rstn, prop)
`define SPMA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

/* rtl/spma_pkg.sv */
// types and codes of the sparse polynomial merge adder
// used by spma_merge, the top level and the testbench; depends on nothing
package spma_pkg;

	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_SUM    = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] coef;
		logic [7:0]         degree;
	} in_t;

	typedef struct packed {
		logic signed [16:0] out_coef;
		logic [7:0]         out_degree;
		logic               last;
		logic               empty_res;
		logic               dropped;
	} out_t;

	typedef struct packed {
		logic signed [15:0] coef;
		logic [7:0]         degree;
	} term_t;

	typedef struct packed {
		logic busy;
		logic done;
	} merge_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

endpackage

/* rtl/spma_ram.sv */
// generic single write port, single read port ram with registered read
// depends on nothing
module spma_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/spma_merge.sv */
// merge sequencer: walks both term lists from ram, one result term per cycle
// depends on spma_pkg, spma_ram read ports and assert_macros.svh
`include "assert_macros.svh"

module spma_merge #(
	parameter int CAP = 16,
	localparam int CW = $clog2(CAP + 1),
	localparam int AW = (CAP > 1) ? $clog2(CAP) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [CW-1:0]         cnt_a,
	input  logic [CW-1:0]         cnt_b,
	input  logic                  ovf,
	output logic [AW-1:0]         raddr_a,
	output logic [AW-1:0]         raddr_b,
	input  spma_pkg::term_t       rdata_a,
	input  spma_pkg::term_t       rdata_b,
	output spma_pkg::merge_stat_t stat,
	output logic                  res_valid,
	output spma_pkg::out_t        res
);

	spma_pkg::state_t   state_q, state_n;
	logic [CW-1:0]      i_q, j_q, i_n, j_n;
	logic               a_ok, b_ok, emit, last, is_empty;
	logic signed [16:0] ca, cb, coef_n;
	logic [7:0]         deg_n;
	logic               res_valid_q;
	spma_pkg::out_t     res_q;

	assign a_ok = (i_q < cnt_a);
	assign b_ok = (j_q < cnt_b);
	assign ca = {rdata_a.coef[15], rdata_a.coef};
	assign cb = {rdata_b.coef[15], rdata_b.coef};

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			spma_pkg::ST_IDLE: begin
				if (go && ((cnt_a != '0) || (cnt_b != '0))) begin
					state_n = spma_pkg::ST_MERGE;
				end
			end
			spma_pkg::ST_MERGE: begin
				if (last) begin
					state_n = spma_pkg::ST_IDLE;
				end
			end
			default: state_n = spma_pkg::ST_IDLE;
		endcase
	end

	// outputs and index steps
	always_comb begin
		i_n = '0;
		j_n = '0;
		emit = 1'b0;
		last = 1'b0;
		is_empty = 1'b0;
		coef_n = '0;
		deg_n = '0;
		case (state_q)
			spma_pkg::ST_IDLE: begin
				if (go && (cnt_a == '0) && (cnt_b == '0)) begin
					emit = 1'b1;
					last = 1'b1;
					is_empty = 1'b1;
				end
			end
			spma_pkg::ST_MERGE: begin
				emit = 1'b1;
				i_n = i_q;
				j_n = j_q;
				if (a_ok && b_ok) begin
					if (rdata_a.degree == rdata_b.degree) begin
						coef_n = ca + cb;
						deg_n = rdata_a.degree;
						i_n = i_q + CW'(1);
						j_n = j_q + CW'(1);
					end else if (rdata_a.degree > rdata_b.degree) begin
						coef_n = ca;
						deg_n = rdata_a.degree;
						i_n = i_q + CW'(1);
					end else begin
						coef_n = cb;
						deg_n = rdata_b.degree;
						j_n = j_q + CW'(1);
					end
				end else if (a_ok) begin
					coef_n = ca;
					deg_n = rdata_a.degree;
					i_n = i_q + CW'(1);
				end else begin
					coef_n = cb;
					deg_n = rdata_b.degree;
					j_n = j_q + CW'(1);
				end
				last = (i_n == cnt_a) && (j_n == cnt_b);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign raddr_a = i_n[AW-1:0];
	assign raddr_b = j_n[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spma_pkg::ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			i_q <= i_n;
			j_q <= j_n;
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.out_coef <= coef_n;
			res_q.out_degree <= deg_n;
			res_q.last <= last;
			res_q.empty_res <= is_empty;
			res_q.dropped <= ovf;
		end
	end

	assign stat.busy = (state_q != spma_pkg::ST_IDLE);
	assign stat.done = emit && last;
	assign res_valid = res_valid_q;
	assign res = res_q;

	`SPMA_ASSERT_NR(a_rst_no_valid, clk, !arst_n |=> !res_valid)
	`SPMA_ASSERT(a_empty_is_last, clk, arst_n, res_valid && res.empty_res |-> res.last)
	`SPMA_ASSERT(a_idx_bound, clk, arst_n,
		state_q == spma_pkg::ST_MERGE |-> (i_q <= cnt_a) && (j_q <= cnt_b)
		&& !((i_q == cnt_a) && (j_q == cnt_b)))
	`SPMA_ASSERT(a_done_idle, clk, arst_n, stat.done |=> state_q == spma_pkg::ST_IDLE)

endmodule

/* rtl/sparse_polynomial_merge_add.sv */
// top level of the sparse polynomial merge adder: term counts, loads, two list rams
// depends on spma_pkg, spma_ram and spma_merge
//
//  channel | direction | handshake            | payload
//  cmd     | in        | start & !busy        | spma_pkg::in_t (func, coef, degree)
//  res     | out       | res_valid, one cycle | spma_pkg::out_t
//
// a load leaves busy low; a sum with terms raises busy and emits one merged
// term per cycle, set by the one read port of each list ram. an empty sum
// emits its result the cycle after it is taken and never raises busy. reset
// clears counts, the drop flag and the sequencer; list contents are not
// cleared. results cannot stall.
module sparse_polynomial_merge_add #(
	parameter int TERM_CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  spma_pkg::in_t  cmd,
	output logic           res_valid,
	output spma_pkg::out_t res
);

	localparam int CW = $clog2(TERM_CAPACITY + 1);
	localparam int AW = (TERM_CAPACITY > 1) ? $clog2(TERM_CAPACITY) : 1;
	localparam int TW = $bits(spma_pkg::term_t);

	logic [CW-1:0]         cnt_a_q, cnt_b_q;
	logic                  ovf_q;
	logic                  accept, load_a, load_b, go;
	logic                  full_a, full_b;
	logic [AW-1:0]         raddr_a, raddr_b;
	logic [TW-1:0]         rdata_a, rdata_b;
	spma_pkg::term_t       wterm;
	spma_pkg::merge_stat_t stat;

	assign accept = start && !busy;
	assign full_a = (cnt_a_q == CW'(TERM_CAPACITY));
	assign full_b = (cnt_b_q == CW'(TERM_CAPACITY));
	assign load_a = accept && (cmd.func == spma_pkg::FUNC_LOAD_A) && !full_a;
	assign load_b = accept && (cmd.func == spma_pkg::FUNC_LOAD_B) && !full_b;
	assign go = accept && (cmd.func == spma_pkg::FUNC_SUM);
	assign wterm.coef = cmd.coef;
	assign wterm.degree = cmd.degree;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ovf_q <= 1'b0;
		end else if (stat.done) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (load_a) begin
				cnt_a_q <= cnt_a_q + CW'(1);
			end
			if (load_b) begin
				cnt_b_q <= cnt_b_q + CW'(1);
			end
			if (accept && (((cmd.func == spma_pkg::FUNC_LOAD_A) && full_a)
				|| ((cmd.func == spma_pkg::FUNC_LOAD_B) && full_b))) begin
				ovf_q <= 1'b1;
			end
		end
	end

	spma_ram #(
		.WIDTH(TW),
		.DEPTH(TERM_CAPACITY)
	) u_ram_a (
		.clk  (clk),
		.we   (load_a),
		.waddr(cnt_a_q[AW-1:0]),
		.wdata(wterm),
		.raddr(raddr_a),
		.rdata(rdata_a)
	);

	spma_ram #(
		.WIDTH(TW),
		.DEPTH(TERM_CAPACITY)
	) u_ram_b (
		.clk  (clk),
		.we   (load_b),
		.waddr(cnt_b_q[AW-1:0]),
		.wdata(wterm),
		.raddr(raddr_b),
		.rdata(rdata_b)
	);

	spma_merge #(
		.CAP(TERM_CAPACITY)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.cnt_a    (cnt_a_q),
		.cnt_b    (cnt_b_q),
		.ovf      (ovf_q),
		.raddr_a  (raddr_a),
		.raddr_b  (raddr_b),
		.rdata_a  (spma_pkg::term_t'(rdata_a)),
		.rdata_b  (spma_pkg::term_t'(rdata_b)),
		.stat     (stat),
		.res_valid(res_valid),
		.res      (res)
	);

	assign busy = stat.busy;

endmodule

/* tb/poly_sum_checker.sv */
`timescale 1ns / 100ps
// checker for the sparse polynomial merge adder: mirrors both term lists, predicts
// the merged terms of every sum and compares each result transaction
// depends on spma_pkg
module poly_sum_checker #(
	parameter int TERM_CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  spma_pkg::in_t  cmd,
	input  logic           res_valid,
	input  spma_pkg::out_t res,
	output int             mismatches,
	output int             pending
);
	import spma_pkg::*;

	term_t       list_a [TERM_CAPACITY];
	term_t       list_b [TERM_CAPACITY];
	int unsigned count_a;
	int unsigned count_b;
	logic        overflow;
	out_t        merged_terms [$];

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic predict_sum();
		out_t        t;
		int unsigned i;
		int unsigned j;
		i = 0;
		j = 0;
		if (count_a == 0 && count_b == 0) begin
			t = '0;
			t.last = 1'b1;
			t.empty_res = 1'b1;
			t.dropped = overflow;
			merged_terms.push_back(t);
		end else begin
			while (i < count_a || j < count_b) begin
				t = '0;
				t.dropped = overflow;
				if (i < count_a && j < count_b && list_a[i].degree == list_b[j].degree) begin
					t.out_coef = $signed(list_a[i].coef) + $signed(list_b[j].coef);
					t.out_degree = list_a[i].degree;
					i++;
					j++;
				end else if (j >= count_b ||
						(i < count_a && list_a[i].degree > list_b[j].degree)) begin
					t.out_coef = $signed(list_a[i].coef);
					t.out_degree = list_a[i].degree;
					i++;
				end else begin
					t.out_coef = $signed(list_b[j].coef);
					t.out_degree = list_b[j].degree;
					j++;
				end
				t.last = (i >= count_a && j >= count_b);
				merged_terms.push_back(t);
			end
		end
		count_a = 0;
		count_b = 0;
		overflow = 1'b0;
	endtask

	task automatic take_command(in_t c);
		term_t t;
		t.coef = c.coef;
		t.degree = c.degree;
		case (c.func)
			FUNC_LOAD_A: begin
				if (count_a < TERM_CAPACITY) begin
					list_a[count_a] = t;
					count_a++;
				end else begin
					overflow = 1'b1;
				end
			end
			FUNC_LOAD_B: begin
				if (count_b < TERM_CAPACITY) begin
					list_b[count_b] = t;
					count_b++;
				end else begin
					overflow = 1'b1;
				end
			end
			FUNC_SUM: begin
				predict_sum();
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_result(out_t got);
		out_t want;
		if (merged_terms.size() == 0) begin
			report($sformatf("unexpected result: coef %0d degree %0d last %b",
				got.out_coef, got.out_degree, got.last));
			return;
		end
		want = merged_terms.pop_front();
		if (got.out_coef !== want.out_coef)
			report($sformatf("out_coef %0d, want %0d", got.out_coef, want.out_coef));
		if (got.out_degree !== want.out_degree)
			report($sformatf("out_degree %0d, want %0d", got.out_degree, want.out_degree));
		if (got.last !== want.last)
			report($sformatf("last %b, want %b", got.last, want.last));
		if (got.empty_res !== want.empty_res)
			report($sformatf("empty_res %b, want %b", got.empty_res, want.empty_res));
		if (got.dropped !== want.dropped)
			report($sformatf("dropped %b, want %b", got.dropped, want.dropped));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a = 0;
			count_b = 0;
			overflow = 1'b0;
			merged_terms.delete();
			pending <= 0;
		end else begin
			if (res_valid)
				check_result(res);
			if (start && !busy)
				take_command(cmd);
			pending <= merged_terms.size();
		end
	end

endmodule

/* tb/tb_sparse_polynomial_merge_add.sv */
`timescale 1ns / 100ps
// testbench top for the sparse polynomial merge adder: drives load, sum and unused commands
// with random gaps, runs a stall watchdog and gives the verdict
// depends on spma_pkg, the rtl and poly_sum_checker
module tb_sparse_polynomial_merge_add;
	import spma_pkg::*;

	localparam int         CAP          = 16;
	localparam int         RANDOM_ITEMS = 480;
	localparam int         STALL_LIMIT  = 2000;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	in_t  cmd    = '0;
	logic busy;
	logic res_valid;
	out_t res;
	int   mismatches;
	int   pending;
	int   items_sent = 0;
	bit   steady     = 1'b0;

	sparse_polynomial_merge_add #(.TERM_CAPACITY(CAP)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res       (res)
	);

	poly_sum_checker #(.TERM_CAPACITY(CAP)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res        (res),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || res_valid)
				idle = 0;
			else
				idle++;
		end
		$display("tb_sparse_polynomial_merge_add NOT OK");
		$finish;
	end

	function automatic logic signed [15:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic term_t term_of(logic signed [15:0] c, logic [7:0] dg);
		term_t t;
		t.coef = c;
		t.degree = dg;
		return t;
	endfunction

	task automatic idle_gap();
		int n;
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			n = 0;
		else if (r < 85)
			n = $urandom_range(1, 3);
		else if (r < 97)
			n = $urandom_range(4, 12);
		else
			n = $urandom_range(20, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic issue(logic [1:0] op, logic signed [15:0] c, logic [7:0] dg);
		start <= 1'b1;
		cmd <= '{func: op, coef: c, degree: dg};
		@(posedge clk);
		while (busy) @(posedge clk);
		if (op != FUNC_UNUSED)
			items_sent++;
		idle_gap();
	endtask

	task automatic drain();
		if (start)
			start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		int i;
		issue(FUNC_SUM, rand_coef(), 8'($urandom));
		issue(FUNC_UNUSED, rand_coef(), 8'($urandom));
		// first list loaded out of order so the last term trails
		issue(FUNC_LOAD_A, 16'sh7fff, 8'd255);
		issue(FUNC_LOAD_A, 16'sd7, 8'd239);
		issue(FUNC_LOAD_A, 16'sh8000, 8'd0);
		issue(FUNC_LOAD_A, 16'sd3, 8'd100);
		// second list filled past capacity, the last load is dropped
		for (i = 0; i <= CAP; i++) begin
			if (i == 0)
				issue(FUNC_LOAD_B, 16'sh7fff, 8'd255);
			else if (i == 1)
				issue(FUNC_LOAD_B, -16'sd7, 8'd239);
			else if (i == CAP - 1)
				issue(FUNC_LOAD_B, 16'sh8000, 8'd0);
			else if (i == CAP)
				issue(FUNC_LOAD_B, rand_coef(), 8'($urandom));
			else
				issue(FUNC_LOAD_B, rand_coef(), 8'(255 - 16 * i));
		end
		issue(FUNC_SUM, rand_coef(), 8'($urandom));
		issue(FUNC_SUM, rand_coef(), 8'($urandom));
	endtask

	task automatic run_round();
		term_t qa [$];
		term_t qb [$];
		term_t t;
		int    mode;
		int    na;
		int    nb;
		int    maxn;
		int    d;
		int    pick;
		steady = ($urandom_range(0, 3) == 0);
		mode = $urandom_range(0, 11);
		if (mode == 0) begin
			// overflow of at least one list
			na = CAP + $urandom_range(1, 3);
			nb = $urandom_range(0, CAP + 2);
			if ($urandom_range(0, 1)) begin
				pick = na;
				na = nb;
				nb = pick;
			end
			repeat (na) qa.push_back(term_of(rand_coef(), 8'($urandom)));
			repeat (nb) qb.push_back(term_of(rand_coef(), 8'($urandom)));
		end else if (mode == 1) begin
			// unsorted lists
			repeat ($urandom_range(0, 8)) qa.push_back(term_of(rand_coef(), 8'($urandom)));
			repeat ($urandom_range(0, 8)) qb.push_back(term_of(rand_coef(), 8'($urandom)));
		end else begin
			// descending degrees, some shared by both lists
			maxn = ($urandom_range(0, 7) == 0) ? CAP : $urandom_range(0, 6);
			d = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 255);
			while (d >= 0 && (qa.size() < maxn || qb.size() < maxn)) begin
				pick = $urandom_range(0, 2);
				if (pick != 1 && qa.size() < maxn)
					qa.push_back(term_of(rand_coef(), 8'(d)));
				if (pick != 0 && qb.size() < maxn)
					qb.push_back(term_of(rand_coef(), 8'(d)));
				d -= $urandom_range(1, (maxn > 8) ? 12 : 40);
			end
		end
		while (qa.size() != 0 || qb.size() != 0) begin
			if ($urandom_range(0, 15) == 0)
				issue(FUNC_UNUSED, rand_coef(), 8'($urandom));
			if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 1)) begin
				t = qa.pop_front();
				issue(FUNC_LOAD_A, t.coef, t.degree);
			end else begin
				t = qb.pop_front();
				issue(FUNC_LOAD_B, t.coef, t.degree);
			end
		end
		issue(FUNC_SUM, rand_coef(), 8'($urandom));
	endtask

	initial begin
		int rounds;
		rounds = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain();
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			run_round();
			rounds++;
			if (rounds % 9 == 0)
				drain();
		end
		drain();
		repeat (2 * CAP + 8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb_sparse_polynomial_merge_add OK");
		else
			$display("tb_sparse_polynomial_merge_add NOT OK");
		$finish;
	end

endmodule
